// ----- hw/rtl/double_ended_queue_assert.svh -----
// Assertion macros used by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQE_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deque check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deque check failed: next-cycle implication");

`endif

// ----- hw/rtl/dqe_pkg.sv -----
// Shared types and codes of the double-ended queue.
package dqe_pkg;

	localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [1:0] KIND_POP_BACK   = 2'd3;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef logic signed [31:0] dqe_word_t;

	// Per-cycle command broadcast to every cell of one chain.
	typedef struct packed {
		logic      push_head;
		logic      pop_head;
		logic      push_tail;
		dqe_word_t wdata;
	} dqe_cell_ctl_t;

endpackage

// ----- hw/rtl/dqe_if.sv -----
// Valid/ready channel interfaces for deque operations and results.
interface dqe_op_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface dqe_res_if #(parameter int COUNT_W = 7);
	logic               valid;
	logic               ready;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output popped_value, output status, output count,
		input ready);
	modport sink (input valid, input popped_value, input status, input count,
		output ready);
endinterface

// ----- hw/rtl/dqe_cell.sv -----
// One storage cell of a deque chain.
module dqe_cell import dqe_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic          clk,
	input  dqe_cell_ctl_t ctl,
	input  logic [CW-1:0] tail,
	input  dqe_word_t     prev_d,
	input  dqe_word_t     next_d,
	output dqe_word_t     d
);

	localparam logic [CW-1:0] SLOT = CW'(IDX);

	dqe_word_t d_q;

	// Shift away from the head, shift towards it, or take a write at the tail slot.
	always_ff @(posedge clk) begin
		if (ctl.push_head) begin
			d_q <= prev_d;
		end else if (ctl.pop_head) begin
			d_q <= next_d;
		end else if (ctl.push_tail && (tail == SLOT)) begin
			d_q <= ctl.wdata;
		end
	end

	assign d = d_q;

endmodule

// ----- hw/rtl/dqe_chain.sv -----
// Row of cells holding the deque in order from a fixed head cell.
module dqe_chain import dqe_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  dqe_cell_ctl_t ctl,
	input  logic [CW-1:0] tail,
	output dqe_word_t     head
);

	dqe_word_t cell_d [DEPTH];
	dqe_word_t prev_d [DEPTH];
	dqe_word_t next_d [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign prev_d[g] = ctl.wdata;
		end else begin : g_inner_prev
			assign prev_d[g] = cell_d[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_d[g] = cell_d[g];
		end else begin : g_inner_next
			assign next_d[g] = cell_d[g+1];
		end

		dqe_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.tail   (tail),
			.prev_d (prev_d[g]),
			.next_d (next_d[g]),
			.d      (cell_d[g])
		);
	end

	assign head = cell_d[0];

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue built from two cell chains.
//
//   channel | modport | moves per transaction
//   --------+---------+--------------------------------------------
//   op      | sink    | kind, value (one deque operation)
//   res     | source  | popped_value, status, count (one result)
//
// Takes one transaction per cycle while op.ready is high; the result is registered and
// shows in the cycle after acceptance. Every operation reads or writes only the head
// cell of a chain or the tail slot picked by the entry count, so each operation needs
// only the single update of the chains and the count register.
// Reset clears the entry count and the result valid flag; cell contents are not reset.
// While a result waits and res.ready is low, op.ready drops and every cell holds.
module double_ended_queue import dqe_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	dqe_op_if.sink    op,
	dqe_res_if.source res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE        = CW'(1);

	// The deque is held twice: the front chain keeps the front entry in its head
	// cell, the back chain keeps the back entry in its head cell, each in order
	// from its own end. A pop at one end shifts that chain towards its head; the
	// other chain simply loses its tail entry through the count.
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          res_valid_q;
	dqe_word_t     popped_q;
	logic [1:0]    status_q;
	logic [CW-1:0] res_count_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          do_push_front;
	logic          do_push_back;
	logic          do_pop_front;
	logic          do_pop_back;
	logic [1:0]    status_d;
	dqe_word_t     popped_d;
	dqe_word_t     front_head;
	dqe_word_t     back_head;
	dqe_cell_ctl_t front_ctl;
	dqe_cell_ctl_t back_ctl;

	// Accept whenever the result register is free or being drained.
	assign op.ready = !res_valid_q || res.ready;
	assign accept   = op.valid && op.ready;

	assign is_full  = (count_q == FULL_COUNT);
	assign is_empty = (count_q == '0);

	// Decode the operation; a dropped push or an empty pop changes nothing.
	always_comb begin
		do_push_front = 1'b0;
		do_push_back  = 1'b0;
		do_pop_front  = 1'b0;
		do_pop_back   = 1'b0;
		status_d      = STATUS_DONE;
		unique case (op.kind)
			KIND_PUSH_FRONT: begin
				if (is_full) status_d = STATUS_FULL;
				else do_push_front = 1'b1;
			end
			KIND_PUSH_BACK: begin
				if (is_full) status_d = STATUS_FULL;
				else do_push_back = 1'b1;
			end
			KIND_POP_FRONT: begin
				if (is_empty) status_d = STATUS_EMPTY;
				else do_pop_front = 1'b1;
			end
			KIND_POP_BACK: begin
				if (is_empty) status_d = STATUS_EMPTY;
				else do_pop_back = 1'b1;
			end
		endcase
	end

	// Take the popped value straight from the head cell of the matching chain.
	always_comb begin
		popped_d = '0;
		if (do_pop_front) popped_d = front_head;
		else if (do_pop_back) popped_d = back_head;
	end

	always_comb begin
		count_d = count_q;
		if (do_push_front || do_push_back) count_d = count_q + ONE;
		else if (do_pop_front || do_pop_back) count_d = count_q - ONE;
	end

	// Front chain: front operations act at its head, back pushes land at its tail.
	assign front_ctl.push_head = accept && do_push_front;
	assign front_ctl.pop_head  = accept && do_pop_front;
	assign front_ctl.push_tail = accept && do_push_back;
	assign front_ctl.wdata     = op.value;

	// Back chain: the mirror image.
	assign back_ctl.push_head = accept && do_push_back;
	assign back_ctl.pop_head  = accept && do_pop_back;
	assign back_ctl.push_tail = accept && do_push_front;
	assign back_ctl.wdata     = op.value;

	dqe_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_front_chain (
		.clk  (clk),
		.ctl  (front_ctl),
		.tail (count_q),
		.head (front_head)
	);

	dqe_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_back_chain (
		.clk  (clk),
		.ctl  (back_ctl),
		.tail (count_q),
		.head (back_head)
	);

	// Advance the count and the result flag on each transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result payload; hold it while the sink stalls.
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q    <= popped_d;
			status_q    <= status_d;
			res_count_q <= count_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.popped_value = popped_q;
	assign res.status       = status_q;
	assign res.count        = res_count_q;

endmodule

// ----- hw/rtl/dqe_checker.sv -----
// Port-level checks of the double-ended queue and their binding.
`include "double_ended_queue_assert.svh"

module dqe_checker import dqe_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               op_valid,
	input logic               op_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [31:0] res_popped_value,
	input logic [1:0]         res_status,
	input logic [CW-1:0]      res_count
);

	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	// A stalled result holds.
	`DQE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(res_popped_value) && $stable(res_status) && $stable(res_count))

	// Every accepted operation leaves a result behind.
	`DQE_ASSERT_NEXT(a_op_gives_res, clk, arst_n, op_valid && op_ready, res_valid)

	// A dropped push only happens on a full deque and returns zero.
	`DQE_ASSERT_HOLDS(a_full_drop, clk, arst_n, res_valid && (res_status == STATUS_FULL),
		(res_count == FULL_COUNT) && (res_popped_value == 32'sd0))

	// An empty pop leaves the deque empty and returns zero.
	`DQE_ASSERT_HOLDS(a_empty_pop, clk, arst_n, res_valid && (res_status == STATUS_EMPTY),
		(res_count == '0) && (res_popped_value == 32'sd0))

	// Count and status stay within their ranges.
	`DQE_ASSERT_HOLDS(a_res_range, clk, arst_n, res_valid,
		(res_count <= FULL_COUNT) && ((res_status == STATUS_DONE) ||
		(res_status == STATUS_EMPTY) || (res_status == STATUS_FULL)))

endmodule

bind double_ended_queue dqe_checker #(
	.DEPTH (DEPTH)
) u_dqe_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.op_valid         (op.valid),
	.op_ready         (op.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_popped_value (res.popped_value),
	.res_status       (res.status),
	.res_count        (res.count)
);
